// ----- sv/dceq_pkg.sv -----
// Shared types, widths and codes for the debounce / coalescing event queue.
// No dependencies; compile first.
package dceq_pkg;

    localparam int QUEUE_DEPTH = 16;   // power of two: slots are addressed as a ring
    localparam int KEY_BITS    = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W      = 32;
    localparam int MCOUNT_W    = 16;
    localparam int TALLY_W     = 32;
    localparam int KIND_W      = 3;
    localparam int LIMIT_W     = 5;
    localparam int REG_IDX_W   = 2;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam logic OP_NOTIFY = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    localparam kind_t KIND_NEW      = kind_t'(0);
    localparam kind_t KIND_MERGED   = kind_t'(1);
    localparam kind_t KIND_DROP_NEW = kind_t'(2);
    localparam kind_t KIND_FIRED    = kind_t'(3);
    localparam kind_t KIND_NONE     = kind_t'(4);

    localparam reg_idx_t REG_QUEUE_LIMIT    = reg_idx_t'(0);
    localparam reg_idx_t REG_DEBOUNCE_TIME  = reg_idx_t'(1);
    localparam reg_idx_t REG_COALESCE_LIMIT = reg_idx_t'(2);

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   first_time;
        logic [TIME_W-1:0]   last_time;
        logic [MCOUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        kind_t               kind;
        logic [KEY_BITS-1:0] fired_key;
        logic [TIME_W-1:0]   first_seen;
        logic [MCOUNT_W-1:0] merge_count;
        logic [CNT_W-1:0]    pending_count;
        logic [TALLY_W-1:0]  enqueued_total;
        logic [TALLY_W-1:0]  fired_total;
        logic [TALLY_W-1:0]  dropped_total;
        logic                last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the accepted word
        logic rd;         // read slot at the scan index
        logic next;       // notify scan: advance past a non-matching slot
        logic coalesce;   // merge into the matching slot and emit
        logic append;     // drop oldest if needed, append, emit
        logic keep;       // drain scan: compact a slot that stays
        logic fire;       // drain scan: remove a due slot, hold its result
        logic finish;     // drain end: emit held result or none-fired marker
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op;
        logic idx_lt_occ;
        logic key_match;
        logic due;
        logic out_free;
        logic pend_valid;
    } ctrl_sts_t;

endpackage

// ----- sv/dceq_if.sv -----
// Valid/ready channel interfaces for the event queue: request, result, config.
// Depends on dceq_pkg.
interface dceq_req_if
    import dceq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [KEY_BITS-1:0] event_key;
    logic [TIME_W-1:0]   time_ms;

    modport source (output valid, operation, event_key, time_ms, input ready);
    modport sink   (input valid, operation, event_key, time_ms, output ready);
endinterface

interface dceq_rsp_if
    import dceq_pkg::*;
();
    logic                valid;
    logic                ready;
    kind_t               kind;
    logic [KEY_BITS-1:0] fired_key;
    logic [TIME_W-1:0]   first_seen;
    logic [MCOUNT_W-1:0] merge_count;
    logic [CNT_W-1:0]    pending_count;
    logic [TALLY_W-1:0]  enqueued_total;
    logic [TALLY_W-1:0]  fired_total;
    logic [TALLY_W-1:0]  dropped_total;
    logic                last;

    modport source (output valid, kind, fired_key, first_seen, merge_count, pending_count,
                    enqueued_total, fired_total, dropped_total, last, input ready);
    modport sink   (input valid, kind, fired_key, first_seen, merge_count, pending_count,
                    enqueued_total, fired_total, dropped_total, last, output ready);
endinterface

interface dceq_cfg_if
    import dceq_pkg::*;
();
    logic        valid;
    logic        ready;
    reg_idx_t    index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/dceq_ctrl.sv -----
// Sequencer for the event queue: steps notify search and drain scan one slot at a time.
// Depends on dceq_pkg; drives dceq_dpath through ctrl_cmd_t.
module dceq_ctrl
    import dceq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD     = 3'd1;
    localparam logic [2:0] S_EV     = 3'd2;
    localparam logic [2:0] S_APPEND = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (sts.idx_lt_occ)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EV;
                end
                else if (sts.op == OP_NOTIFY)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_EV:
            begin
                if (sts.op == OP_NOTIFY)
                begin
                    if (!sts.key_match)
                    begin
                        cmd.next   = 1'b1;
                        state_next = S_RD;
                    end
                    else if (sts.out_free)
                    begin
                        cmd.coalesce = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    if (!sts.due)
                    begin
                        cmd.keep   = 1'b1;
                        state_next = S_RD;
                    end
                    else if (!sts.pend_valid || sts.out_free)
                    begin
                        cmd.fire   = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_APPEND:
            begin
                if (sts.out_free)
                begin
                    cmd.append = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/dceq_dpath.sv -----
// Datapath of the event queue: slot ring memory, pointers, tallies, config and result registers.
// Depends on dceq_pkg; commanded by dceq_ctrl.
module dceq_dpath
    import dceq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic                req_operation,
    input  logic [KEY_BITS-1:0] req_event_key,
    input  logic [TIME_W-1:0]   req_time_ms,
    input  logic                cfg_we,
    input  reg_idx_t            cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                rsp_ready,
    output logic                rsp_valid,
    output result_t             rsp_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rdata_reg;

    logic                op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [TIME_W-1:0]   time_reg;

    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic [CNT_W-1:0]   fired_reg, fired_next;
    logic [TALLY_W-1:0] ntally_reg, ntally_next;
    logic [TALLY_W-1:0] ftally_reg, ftally_next;
    logic [TALLY_W-1:0] dtally_reg, dtally_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [TIME_W-1:0]  debounce_reg;
    logic [TIME_W-1:0]  coalesce_reg;

    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    logic [TIME_W-1:0]   quiet;
    logic [TIME_W-1:0]   age;
    logic [CNT_W-1:0]    limit_eff;
    logic                drop;
    logic [MCOUNT_W-1:0] cnt_sat;
    logic                out_free;

    assign rd_addr  = head_reg + idx_reg[ADDR_W-1:0];
    assign quiet    = time_reg - rdata_reg.last_time;
    assign age      = time_reg - rdata_reg.first_time;
    assign out_free = !out_valid_reg || rsp_ready;
    assign cnt_sat  = (&rdata_reg.count) ? rdata_reg.count : rdata_reg.count + 1'b1;

    // zero acts as one, anything above the depth acts as the depth
    always_comb
    begin
        if (limit_reg == '0)
        begin
            limit_eff = CNT_W'(1);
        end
        else if (int'(limit_reg) > QUEUE_DEPTH)
        begin
            limit_eff = CNT_W'(QUEUE_DEPTH);
        end
        else
        begin
            limit_eff = CNT_W'(limit_reg);
        end
    end

    assign drop = (occ_reg >= limit_eff);

    assign sts.op         = op_reg;
    assign sts.idx_lt_occ = (idx_reg < occ_reg);
    assign sts.key_match  = (rdata_reg.key == key_reg);
    assign sts.due        = (quiet >= debounce_reg) || (age >= coalesce_reg);
    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // memory write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_addr;
        mem_wdata = rdata_reg;
        if (cmd.coalesce)
        begin
            mem_we              = 1'b1;
            mem_wdata.last_time = time_reg;
            mem_wdata.count     = cnt_sat;
        end
        else if (cmd.append)
        begin
            // ring slot after the tail; with a drop the head also moves past the oldest slot
            mem_we    = 1'b1;
            mem_waddr = head_reg + occ_reg[ADDR_W-1:0];
            mem_wdata = '{key: key_reg, first_time: time_reg, last_time: time_reg,
                          count: MCOUNT_W'(1)};
        end
        else if (cmd.keep && (wr_reg != idx_reg))
        begin
            mem_we    = 1'b1;
            mem_waddr = head_reg + wr_reg[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        head_next       = head_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        wr_next         = wr_reg;
        fired_next      = fired_reg;
        ntally_next     = ntally_reg;
        ftally_next     = ftally_reg;
        dtally_next     = dtally_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;

        if (cmd.load)
        begin
            idx_next   = '0;
            wr_next    = '0;
            fired_next = '0;
            if (req_operation == OP_NOTIFY)
            begin
                ntally_next = ntally_reg + 1'b1;
            end
        end

        if (cmd.next)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.coalesce)
        begin
            out_valid_next = 1'b1;
            out_next = '{kind: KIND_MERGED, fired_key: key_reg,
                         first_seen: rdata_reg.first_time, merge_count: cnt_sat,
                         pending_count: occ_reg, enqueued_total: ntally_reg,
                         fired_total: ftally_reg, dropped_total: dtally_reg, last: 1'b1};
        end

        if (cmd.append)
        begin
            if (drop)
            begin
                head_next   = head_reg + 1'b1;
                dtally_next = dtally_reg + 1'b1;
                occ_next    = occ_reg;
            end
            else
            begin
                occ_next = occ_reg + 1'b1;
            end
            out_valid_next = 1'b1;
            out_next = '{kind: (drop ? KIND_DROP_NEW : KIND_NEW), fired_key: key_reg,
                         first_seen: time_reg, merge_count: MCOUNT_W'(1),
                         pending_count: occ_next, enqueued_total: ntally_reg,
                         fired_total: ftally_reg, dropped_total: dtally_next, last: 1'b1};
        end

        if (cmd.keep)
        begin
            idx_next = idx_reg + 1'b1;
            wr_next  = wr_reg + 1'b1;
        end

        if (cmd.fire)
        begin
            idx_next    = idx_reg + 1'b1;
            fired_next  = fired_reg + 1'b1;
            ftally_next = ftally_reg + 1'b1;
            // release the previous fired result, it is not the final one
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next = '{kind: KIND_FIRED, fired_key: rdata_reg.key,
                          first_seen: rdata_reg.first_time, merge_count: rdata_reg.count,
                          pending_count: occ_reg - fired_next, enqueued_total: ntally_reg,
                          fired_total: ftally_next, dropped_total: dtally_reg, last: 1'b0};
        end

        if (cmd.finish)
        begin
            occ_next        = wr_reg;
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            if (pend_valid_reg)
            begin
                out_next      = pend_reg;
                out_next.last = 1'b1;
            end
            else
            begin
                out_next = '{kind: KIND_NONE, fired_key: '0, first_seen: '0,
                             merge_count: '0, pending_count: wr_reg,
                             enqueued_total: ntally_reg, fired_total: ftally_reg,
                             dropped_total: dtally_reg, last: 1'b1};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            occ_reg        <= '0;
            idx_reg        <= '0;
            wr_reg         <= '0;
            fired_reg      <= '0;
            ntally_reg     <= '0;
            ftally_reg     <= '0;
            dtally_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            limit_reg      <= LIMIT_W'(16);
            debounce_reg   <= TIME_W'(100);
            coalesce_reg   <= TIME_W'(1000);
        end
        else
        begin
            head_reg       <= head_next;
            occ_reg        <= occ_next;
            idx_reg        <= idx_next;
            wr_reg         <= wr_next;
            fired_reg      <= fired_next;
            ntally_reg     <= ntally_next;
            ftally_reg     <= ftally_next;
            dtally_reg     <= dtally_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_QUEUE_LIMIT:    limit_reg    <= cfg_data[LIMIT_W-1:0];
                    REG_DEBOUNCE_TIME:  debounce_reg <= cfg_data[TIME_W-1:0];
                    REG_COALESCE_LIMIT: coalesce_reg <= cfg_data[TIME_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= req_operation;
            key_reg  <= req_event_key;
            time_reg <= req_time_ms;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

// ----- sv/debounce_coalescing_event_queue_core.sv -----
// Debounce / coalescing event queue: top level joining sequencer, datapath and channels.
// Depends on dceq_pkg, dceq_if, dceq_ctrl and dceq_dpath.
//
// Channels: req carries one word per operation (notify a key, or drain due entries
// at time_ms); rsp returns result words, the final one of each request marked by last;
// cfg writes queue_limit, debounce_time and coalesce_limit by index and is always ready.
// Write cfg only while the block is idle.
//
// Timing: one request is in work at a time. Notify search and drain scan step
// through the pending entries one at a time over the single read port of the
// slot memory: each entry is read, then judged in the next cycle.
// Fired results leave one entry behind the scan, so last can be set on the final one.
//
// Reset clears the queue (occupancy and ring head), the three totals and restores
// the register defaults 16, 100 and 1000; slot contents are not cleared.
// A stalled receiver holds the output word; the scan waits only when a new result
// must be handed over, and the next request is accepted while a result still waits.
module debounce_coalescing_event_queue_core
    import dceq_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    dceq_cfg_if.sink   cfg,
    dceq_req_if.sink   req,
    dceq_rsp_if.source rsp
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    result_t   result;
    logic      req_ready;

    assign cfg.ready = 1'b1;
    assign req.ready = req_ready;

    dceq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dceq_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_operation (req.operation),
        .req_event_key (req.event_key),
        .req_time_ms   (req.time_ms),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .rsp_ready     (rsp.ready),
        .rsp_valid     (rsp.valid),
        .rsp_data      (result)
    );

    // unpack the result word onto the channel
    assign rsp.kind           = result.kind;
    assign rsp.fired_key      = result.fired_key;
    assign rsp.first_seen     = result.first_seen;
    assign rsp.merge_count    = result.merge_count;
    assign rsp.pending_count  = result.pending_count;
    assign rsp.enqueued_total = result.enqueued_total;
    assign rsp.fired_total    = result.fired_total;
    assign rsp.dropped_total  = result.dropped_total;
    assign rsp.last           = result.last;

endmodule

// ----- sim/debounce_coalescing_event_queue_core_tb.sv -----
// Testbench for the debounce / coalescing event queue core: random and directed notify and
// drain words, results checked against an in-bench queue predictor kept in a scoreboard class.
// Depends on dceq_pkg, dceq_if and debounce_coalescing_event_queue_core.
module debounce_coalescing_event_queue_core_tb;
    import dceq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Queue predictor and store of expected result words.
    class event_queue_board;
        logic [KEY_BITS-1:0] key_q[$];
        logic [TIME_W-1:0]   first_q[$];
        logic [TIME_W-1:0]   seen_q[$];
        logic [MCOUNT_W-1:0] merges_q[$];
        logic [TALLY_W-1:0]  n_notify, n_fire, n_drop;
        logic [LIMIT_W-1:0]  limit_reg;
        logic [31:0]         quiet_reg, age_reg;
        result_t             expected_q[$];
        int                  mismatches;

        function new();
            n_notify = '0;
            n_fire = '0;
            n_drop = '0;
            limit_reg = LIMIT_W'(16);
            quiet_reg = 32'd100;
            age_reg = 32'd1000;
            mismatches = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] val);
            if (idx == REG_QUEUE_LIMIT) limit_reg = val[LIMIT_W-1:0];
            else if (idx == REG_DEBOUNCE_TIME) quiet_reg = val;
            else if (idx == REG_COALESCE_LIMIT) age_reg = val;
        endfunction

        function result_t make_word(kind_t k, logic [31:0] key, logic [31:0] first,
                                    logic [15:0] cnt, int pend, logic lst);
            result_t r;
            r.kind = k;
            r.fired_key = key;
            r.first_seen = first;
            r.merge_count = cnt;
            r.pending_count = CNT_W'(pend);
            r.enqueued_total = n_notify;
            r.fired_total = n_fire;
            r.dropped_total = n_drop;
            r.last = lst;
            return r;
        endfunction

        // Note one accepted request word and queue the results it causes.
        function void note_request(logic op, logic [KEY_BITS-1:0] key, logic [TIME_W-1:0] now);
            int lim;
            int fired;
            kind_t k;
            logic [31:0] quiet, age;
            if (op == OP_NOTIFY)
            begin
                n_notify++;
                foreach (key_q[i])
                    if (key_q[i] == key)
                    begin
                        seen_q[i] = now;
                        if (merges_q[i] != 16'hFFFF) merges_q[i]++;
                        expected_q.insert(expected_q.size(),
                                          make_word(KIND_MERGED, key, first_q[i],
                                                    merges_q[i], key_q.size(), 1'b1));
                        return;
                    end
                lim = (limit_reg == 0) ? 1 : (limit_reg > QUEUE_DEPTH ? QUEUE_DEPTH : limit_reg);
                k = KIND_NEW;
                if (key_q.size() >= lim)
                begin
                    key_q.delete(0);
                    first_q.delete(0);
                    seen_q.delete(0);
                    merges_q.delete(0);
                    n_drop++;
                    k = KIND_DROP_NEW;
                end
                key_q.insert(key_q.size(), key);
                first_q.insert(first_q.size(), now);
                seen_q.insert(seen_q.size(), now);
                merges_q.insert(merges_q.size(), 16'd1);
                expected_q.insert(expected_q.size(),
                                  make_word(k, key, now, 16'd1, key_q.size(), 1'b1));
            end
            else
            begin
                int total;
                int i;
                total = key_q.size();
                fired = 0;
                i = 0;
                // Walk the queue; keep entries that are not due, in order.
                for (int rd = 0; rd < total; rd++)
                begin
                    quiet = now - seen_q[i];
                    age = now - first_q[i];
                    if ((quiet >= quiet_reg || age >= age_reg) && fired < 16)
                    begin
                        n_fire++;
                        fired++;
                        expected_q.insert(expected_q.size(),
                                          make_word(KIND_FIRED, key_q[i], first_q[i],
                                                    merges_q[i], total - fired, 1'b0));
                        key_q.delete(i);
                        first_q.delete(i);
                        seen_q.delete(i);
                        merges_q.delete(i);
                    end
                    else i++;
                end
                if (fired == 0)
                    expected_q.insert(expected_q.size(),
                                      make_word(KIND_NONE, '0, '0, '0, key_q.size(), 1'b1));
                else
                    expected_q[$].last = 1'b1;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        // Compare one result word with the oldest expectation.
        task check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result word %h", got));
                return;
            end
            exp = expected_q[0];
            expected_q.delete(0);
            if (got.kind != exp.kind)
                report($sformatf("kind %0d, want %0d", got.kind, exp.kind));
            if (got.fired_key != exp.fired_key)
                report($sformatf("fired_key %h, want %h", got.fired_key, exp.fired_key));
            if (got.first_seen != exp.first_seen)
                report($sformatf("first_seen %h, want %h", got.first_seen, exp.first_seen));
            if (got.merge_count != exp.merge_count)
                report($sformatf("merge_count %0d, want %0d", got.merge_count, exp.merge_count));
            if (got.pending_count != exp.pending_count)
                report($sformatf("pending_count %0d, want %0d",
                                 got.pending_count, exp.pending_count));
            if (got.enqueued_total != exp.enqueued_total)
                report($sformatf("enqueued_total %0d, want %0d",
                                 got.enqueued_total, exp.enqueued_total));
            if (got.fired_total != exp.fired_total)
                report($sformatf("fired_total %0d, want %0d", got.fired_total, exp.fired_total));
            if (got.dropped_total != exp.dropped_total)
                report($sformatf("dropped_total %0d, want %0d",
                                 got.dropped_total, exp.dropped_total));
            if (got.last != exp.last)
                report($sformatf("last %0d, want %0d", got.last, exp.last));
        endtask
    endclass

    logic clk;
    logic rst_n;
    longint unsigned cycle_count = 0;
    event_queue_board board;

    // A generous limit on the whole run, with room for every scan plus stalls.
    localparam longint unsigned CYCLE_LIMIT = 600000;

    dceq_cfg_if cfg ();
    dceq_req_if req ();
    dceq_rsp_if rsp ();

    debounce_coalescing_event_queue_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg.sink),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Small key pool so merges are common; occasional wide random keys.
    logic [31:0] key_pool[8];
    logic [31:0] clock_ms;

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("debounce_coalescing_event_queue_core_tb: errors");
            $finish;
        end
    end

    // Receiver: stall on its own pattern, with long stall-free stretches.
    always @(posedge clk)
    begin
        result_t got;
        if (rsp.valid && rsp.ready)
        begin
            got.kind = rsp.kind;
            got.fired_key = rsp.fired_key;
            got.first_seen = rsp.first_seen;
            got.merge_count = rsp.merge_count;
            got.pending_count = rsp.pending_count;
            got.enqueued_total = rsp.enqueued_total;
            got.fired_total = rsp.fired_total;
            got.dropped_total = rsp.dropped_total;
            got.last = rsp.last;
            board.check_result(got);
        end
        if (!rst_n) rsp.ready <= 1'b0;
        else if (cycle_count % 1500 < 500) rsp.ready <= 1'b1;
        else if (cycle_count % 1500 < 1000) rsp.ready <= ($urandom_range(0, 3) != 0);
        else rsp.ready <= ($urandom_range(0, 3) == 0);
    end

    // Send one request word; hold it until accepted, then note it.
    task send_word(logic op, logic [31:0] key, logic [31:0] now);
        req.valid <= 1'b1;
        req.operation <= op;
        req.event_key <= key;
        req.time_ms <= now;
        do @(posedge clk); while (!req.ready);
        board.note_request(op, key, now);
    endtask

    task idle_gap(int n);
        req.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every expected word, then let the scan settle before a register write.
    task wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_register(reg_idx_t idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        board.set_register(idx, val);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random phase: mostly notifies on pooled keys with drains mixed in; time advances
    // by small random steps, with occasional large jumps, so entries mature at different drains.
    task random_phase(int count);
        int burst;
        logic op;
        logic [31:0] key;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
            end
            burst--;
            clock_ms += $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 150);
            op = ($urandom_range(0, 3) == 0) ? OP_DRAIN : OP_NOTIFY;
            key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
            send_word(op, key, clock_ms);
        end
        wait_idle();
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_NOTIFY;
        req.event_key = '0;
        req.time_ms = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_QUEUE_LIMIT;
        cfg.data = '0;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        clock_ms = 32'hFFFF_FF00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: new, merge, extreme keys, drain with nothing due, time wrap, fire.
        send_word(OP_NOTIFY, 32'h0000_0000, 32'hFFFF_FFF0);
        send_word(OP_NOTIFY, 32'hFFFF_FFFF, 32'hFFFF_FFF8);
        send_word(OP_NOTIFY, 32'h0000_0000, 32'h0000_0004);
        send_word(OP_DRAIN, 32'hFFFF_FFFF, 32'h0000_0010);
        send_word(OP_DRAIN, 32'h0, 32'h0000_0100);
        send_word(OP_DRAIN, 32'h0, 32'h0000_0200);
        // Fill past the limit to force drops, then fire many at once.
        for (int i = 0; i < 18; i++) send_word(OP_NOTIFY, 32'h100 + i, 32'h1000 + i);
        send_word(OP_DRAIN, 32'h0, 32'h2000);
        wait_idle();

        // Limit zero acts as one; lower the limit while ten entries are pending.
        for (int i = 0; i < 10; i++) send_word(OP_NOTIFY, 32'h200 + i, 32'h3000);
        wait_idle();
        write_register(REG_QUEUE_LIMIT, 32'd0);
        write_register(REG_DEBOUNCE_TIME, 32'hFFFF_FFFF);
        write_register(REG_COALESCE_LIMIT, 32'hFFFF_FFFF);
        send_word(OP_NOTIFY, 32'h300, 32'h3001);
        send_word(OP_NOTIFY, 32'h301, 32'h3002);
        send_word(OP_DRAIN, 32'h0, 32'h3003);
        wait_idle();
        write_register(REG_DEBOUNCE_TIME, 32'd0);
        write_register(REG_COALESCE_LIMIT, 32'd0);
        send_word(OP_DRAIN, 32'h0, 32'h3004);
        wait_idle();

        // Limit above depth acts as the depth.
        write_register(REG_QUEUE_LIMIT, 32'd31);
        write_register(REG_DEBOUNCE_TIME, 32'd100);
        write_register(REG_COALESCE_LIMIT, 32'd1000);
        random_phase(150);

        write_register(REG_QUEUE_LIMIT, 32'd4);
        write_register(REG_DEBOUNCE_TIME, $urandom_range(10, 300));
        write_register(REG_COALESCE_LIMIT, $urandom_range(100, 2000));
        random_phase(160);

        write_register(REG_QUEUE_LIMIT, 32'd1);
        write_register(REG_DEBOUNCE_TIME, 32'hFFFF_FFFF);
        write_register(REG_COALESCE_LIMIT, 32'd50);
        random_phase(80);

        write_register(REG_QUEUE_LIMIT, 32'd16);
        write_register(REG_DEBOUNCE_TIME, 32'd0);
        write_register(REG_COALESCE_LIMIT, 32'hFFFF_FFFF);
        random_phase(80);

        repeat (60) @(posedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("debounce_coalescing_event_queue_core_tb: clean");
        else
            $display("debounce_coalescing_event_queue_core_tb: errors");
        $finish;
    end
endmodule
